// ----- rtl/arm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer rotation match package
// Widths, fixed-point constants and shared types for the rotation match
// pipeline.
// ----------------------------------------------------------------------------
package arm_pkg;

    localparam int AXIS_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = AXIS_W + COEF_W;
    localparam int DIFF_W    = 18;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int SQS_W     = 17;
    localparam int DIST_W    = 19;
    localparam int NUM_POSES = 3;
    localparam int NUM_AXES  = 3;
    localparam int UNIT_Q16  = 65536;

    localparam logic signed [COEF_W-1:0] HALF_ROOT2_Q16 = 17'sd46341;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS     = PROD_W'(UNIT_Q16 - 1);

    typedef enum logic [1:0] {
        ROT_ZERO  = 2'd0,
        ROT_PLUS  = 2'd1,
        ROT_MINUS = 2'd2
    } rot_t;

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic [NUM_POSES-1:0][NUM_AXES-1:0][DIFF_W-1:0] d;
    } diff_set_t;

    typedef struct packed {
        logic [NUM_POSES-1:0][DIST_W-1:0] dists;
    } dist_set_t;

endpackage
`default_nettype wire

// ----- rtl/arm_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Carries one core and one frame accelerometer reading per request.
// ----------------------------------------------------------------------------
interface arm_in_if import arm_pkg::*;;

    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] core_x;
    logic signed [AXIS_W-1:0] core_y;
    logic signed [AXIS_W-1:0] core_z;
    logic signed [AXIS_W-1:0] frame_x;
    logic signed [AXIS_W-1:0] frame_y;
    logic signed [AXIS_W-1:0] frame_z;

    modport source (
        output valid, core_x, core_y, core_z, frame_x, frame_y, frame_z,
        input  ready
    );

    modport sink (
        input  valid, core_x, core_y, core_z, frame_x, frame_y, frame_z,
        output ready
    );

endinterface
`default_nettype wire

// ----- rtl/arm_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Carries the three pose distances and the index of the closest pose.
// ----------------------------------------------------------------------------
interface arm_out_if import arm_pkg::*;;

    logic              valid;
    logic              ready;
    logic [1:0]        best_rotation;
    logic [DIST_W-1:0] dist_zero;
    logic [DIST_W-1:0] dist_plus;
    logic [DIST_W-1:0] dist_minus;

    modport source (
        output valid, best_rotation, dist_zero, dist_plus, dist_minus,
        input  ready
    );

    modport sink (
        input  valid, best_rotation, dist_zero, dist_plus, dist_minus,
        output ready
    );

endinterface
`default_nettype wire

// ----- rtl/accel_rotation_match.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer rotation match
// Rotates a core accelerometer vector into three fixed poses (0, +120 and
// -120 degrees), measures the scaled squared distance of each to a frame
// vector and reports the closest pose.
// ----------------------------------------------------------------------------
// The block is a five-stage pipeline that takes one sample request in every
// cycle when the result side does not stall, and returns one result request
// for each. Stage one scales the x and y axes by half root two, stage two
// forms the rotated components and their differences to the frame vector,
// stage three squares them, stage four sums the axes of each pose and stage
// five picks the smallest distance into the output register. A stall on the
// result side is absorbed by the empty stages first, so sample ready drops
// only when all five stages hold data.
module accel_rotation_match
    import arm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    arm_in_if.sink     sample,
    arm_out_if.source  result
);

    logic      rot_valid;
    logic      rot_ready;
    diff_set_t rot_data;
    logic      dist_valid;
    logic      dist_ready;
    dist_set_t dist_data;

    arm_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    arm_distance u_distance (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_data  (dist_data)
    );

    arm_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dist_valid),
        .in_ready (dist_ready),
        .in_data  (dist_data),
        .result   (result)
    );

endmodule
`default_nettype wire

// ----- rtl/arm_rotate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation stages
// Scales the core x and y axes by half root two, then forms the rotated
// components of all three poses and their differences to the frame vector.
// ----------------------------------------------------------------------------
module arm_rotate
    import arm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    arm_in_if.sink     sample,
    output logic       out_valid,
    input  wire logic  out_ready,
    output diff_set_t  out_data
);

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [AXIS_W-1:0] cz_reg;
    logic signed [AXIS_W-1:0] fx_reg;
    logic signed [AXIS_W-1:0] fy_reg;
    logic signed [AXIS_W-1:0] fz_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;

    logic                     s2_valid_reg;
    diff_set_t                diff_reg;
    diff_set_t                diff_next;

    logic                     adv1;
    logic                     adv2;

    logic signed [PROD_W-1:0] rnd_x;
    logic signed [PROD_W-1:0] rnd_y;
    diff_t                    hx;
    diff_t                    hy;
    diff_t                    cz;
    diff_t                    fx;
    diff_t                    fy;
    diff_t                    fz;

    assign adv2         = !s2_valid_reg || out_ready;
    assign adv1         = !s1_valid_reg || adv2;
    assign sample.ready = adv1;
    assign out_valid    = s2_valid_reg;
    assign out_data     = diff_reg;

    assign prod_x_next = sample.core_x * HALF_ROOT2_Q16;
    assign prod_y_next = sample.core_y * HALF_ROOT2_Q16;

    // Products are truncated toward zero, so negative ones are biased first.
    assign rnd_x = prod_x_reg + (prod_x_reg[PROD_W-1] ? TRUNC_BIAS : '0);
    assign rnd_y = prod_y_reg + (prod_y_reg[PROD_W-1] ? TRUNC_BIAS : '0);
    assign hx    = DIFF_W'($signed(rnd_x[FRAC_W+AXIS_W-1:FRAC_W]));
    assign hy    = DIFF_W'($signed(rnd_y[FRAC_W+AXIS_W-1:FRAC_W]));
    assign cz    = DIFF_W'(cz_reg);
    assign fx    = DIFF_W'(fx_reg);
    assign fy    = DIFF_W'(fy_reg);
    assign fz    = DIFF_W'(fz_reg);

    always_comb
    begin
        diff_next.d[0][0] = cz - fx;
        diff_next.d[0][1] = (hy - hx) - fy;
        diff_next.d[0][2] = (-hx - hy) - fz;
        diff_next.d[1][0] = (hx + hy) - fx;
        diff_next.d[1][1] = -cz - fy;
        diff_next.d[1][2] = (hy - hx) - fz;
        diff_next.d[2][0] = (hx - hy) - fx;
        diff_next.d[2][1] = (-hx - hy) - fy;
        diff_next.d[2][2] = -cz - fz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && sample.valid)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            cz_reg     <= sample.core_z;
            fx_reg     <= sample.frame_x;
            fy_reg     <= sample.frame_y;
            fz_reg     <= sample.frame_z;
        end
        if (adv2 && s1_valid_reg)
        begin
            diff_reg <= diff_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/arm_distance.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Distance stages
// Squares every axis difference, scales it down by 2^16 and sums the three
// axes of each pose.
// ----------------------------------------------------------------------------
module arm_distance
    import arm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire diff_set_t  in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dist_set_t       out_data
);

    logic                    s3_valid_reg;
    logic [SQS_W-1:0]        sq_reg   [NUM_POSES][NUM_AXES];
    logic [SQS_W-1:0]        sq_next  [NUM_POSES][NUM_AXES];
    logic signed [SQ_W-1:0]  sq_full  [NUM_POSES][NUM_AXES];

    logic                    s4_valid_reg;
    dist_set_t               dist_reg;
    dist_set_t               dist_next;

    logic                    adv3;
    logic                    adv4;

    assign adv4      = !s4_valid_reg || out_ready;
    assign adv3      = !s3_valid_reg || adv4;
    assign in_ready  = adv3;
    assign out_valid = s4_valid_reg;
    assign out_data  = dist_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_POSES; p++)
        begin
            for (int r = 0; r < NUM_AXES; r++)
            begin
                sq_full[p][r] = $signed(in_data.d[p][r]) * $signed(in_data.d[p][r]);
                sq_next[p][r] = sq_full[p][r][FRAC_W+SQS_W-1:FRAC_W];
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_POSES; p++)
        begin
            dist_next.dists[p] = DIST_W'(sq_reg[p][0]) + DIST_W'(sq_reg[p][1])
                               + DIST_W'(sq_reg[p][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                s3_valid_reg <= in_valid;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && in_valid)
        begin
            sq_reg <= sq_next;
        end
        if (adv4 && s3_valid_reg)
        begin
            dist_reg <= dist_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/arm_select.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pose selection stage
// Picks the pose with the smallest distance, the lower index winning ties,
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module arm_select
    import arm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dist_set_t  in_data,
    arm_out_if.source       result
);

    logic              valid_reg;
    rot_t              best_reg;
    rot_t              best_next;
    logic [DIST_W-1:0] d0_reg;
    logic [DIST_W-1:0] d1_reg;
    logic [DIST_W-1:0] d2_reg;
    logic [DIST_W-1:0] low01;
    logic              plus_lower;

    assign in_ready             = !valid_reg || result.ready;
    assign result.valid         = valid_reg;
    assign result.best_rotation = best_reg;
    assign result.dist_zero     = d0_reg;
    assign result.dist_plus     = d1_reg;
    assign result.dist_minus    = d2_reg;

    assign plus_lower = in_data.dists[1] < in_data.dists[0];
    assign low01      = plus_lower ? in_data.dists[1] : in_data.dists[0];

    always_comb
    begin
        priority if (in_data.dists[2] < low01)
        begin
            best_next = ROT_MINUS;
        end
        else if (plus_lower)
        begin
            best_next = ROT_PLUS;
        end
        else
        begin
            best_next = ROT_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            best_reg <= best_next;
            d0_reg   <= in_data.dists[0];
            d1_reg   <= in_data.dists[1];
            d2_reg   <= in_data.dists[2];
        end
    end

`ifndef SYNTHESIS
    a_zero_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && best_reg == ROT_ZERO) |-> (d0_reg <= d1_reg && d0_reg <= d2_reg))
        else $error("Zero pose chosen but it is not the smallest distance.");

    a_plus_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && best_reg == ROT_PLUS) |-> (d1_reg < d0_reg && d1_reg <= d2_reg))
        else $error("Plus pose chosen but it is not the first smallest distance.");

    a_minus_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && best_reg == ROT_MINUS) |-> (d2_reg < d0_reg && d2_reg < d1_reg))
        else $error("Minus pose chosen but it is not the first smallest distance.");

    a_taken_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg)
        else $error("A taken request did not reach the output register.");
`endif

endmodule
`default_nettype wire
